### design/utf8ld_pkg.sv
// Package for the lenient UTF-8 decoder: widths, constants, the result bundle
// passed from the byte decoder to the result queue, and code point helpers.
// No dependencies.
package utf8ld_pkg;

    localparam int ByteW      = 8;
    localparam int CpW        = 21;
    localparam int MaxResults = 3;
    localparam int CountW     = 2;
    // Room for one result still waiting plus a full burst from the next byte.
    localparam int QueueDepth = 4;

    localparam logic [CpW-1:0] CP_REPLACEMENT = 21'h00FFFD;

    typedef struct packed {
        logic [CountW-1:0]                count;
        logic [MaxResults-1:0][CpW-1:0]   cp;
    } step_result_t;

    function automatic logic is_ascii(input logic [ByteW-1:0] b);
        return (b[7] == 1'b0);
    endfunction

    function automatic logic is_lead2(input logic [ByteW-1:0] b);
        return (b[7:5] == 3'b110);
    endfunction

    function automatic logic is_lead3(input logic [ByteW-1:0] b);
        return (b[7:4] == 4'b1110);
    endfunction

    function automatic logic is_lead4(input logic [ByteW-1:0] b);
        return (b[7:3] == 5'b11110);
    endfunction

    function automatic logic [CpW-1:0] from_ascii(input logic [ByteW-1:0] b);
        return {13'd0, b};
    endfunction

    function automatic logic [CpW-1:0] join2(input logic [ByteW-1:0] a,
                                             input logic [ByteW-1:0] b);
        return {10'd0, a[4:0], b[5:0]};
    endfunction

    function automatic logic [CpW-1:0] join3(input logic [ByteW-1:0] a,
                                             input logic [ByteW-1:0] b,
                                             input logic [ByteW-1:0] c);
        return {5'd0, a[3:0], b[5:0], c[5:0]};
    endfunction

    function automatic logic [CpW-1:0] join4(input logic [ByteW-1:0] a,
                                             input logic [ByteW-1:0] b,
                                             input logic [ByteW-1:0] c,
                                             input logic [ByteW-1:0] d);
        return {a[2:0], b[5:0], c[5:0], d[5:0]};
    endfunction

endpackage

### design/utf8ld_decode.sv
// Byte decoder for the lenient UTF-8 decoder: sequence state registers and the
// single-pass logic that turns one byte into zero to three code points.
// Depends on utf8ld_pkg.
module utf8ld_decode (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [utf8ld_pkg::ByteW-1:0]  in_byte,
    input  logic                          in_accept,
    output utf8ld_pkg::step_result_t      result
);
    import utf8ld_pkg::*;

    logic [ByteW-1:0]  lead_reg, lead_next;
    logic [1:0]        needed_reg, needed_next;
    logic [1:0]        held_cnt_reg, held_cnt_next;
    logic [ByteW-1:0]  held_reg [2];
    logic              held_wr;
    logic [ByteW-1:0]  c0, c1;

    assign c0 = held_reg[0];
    assign c1 = held_reg[1];

    always_comb begin
        result        = '0;
        lead_next     = lead_reg;
        needed_next   = needed_reg;
        held_cnt_next = held_cnt_reg;
        held_wr       = 1'b0;

        if (needed_reg == 2'd0) begin
            if (in_byte == '0) begin
                result.count = 2'd0;
            end else if (is_ascii(in_byte)) begin
                result.count = 2'd1;
                result.cp[0] = from_ascii(in_byte);
            end else if (is_lead2(in_byte)) begin
                lead_next     = in_byte;
                needed_next   = 2'd1;
                held_cnt_next = 2'd0;
            end else if (is_lead3(in_byte)) begin
                lead_next     = in_byte;
                needed_next   = 2'd2;
                held_cnt_next = 2'd0;
            end else if (is_lead4(in_byte)) begin
                lead_next     = in_byte;
                needed_next   = 2'd3;
                held_cnt_next = 2'd0;
            end else begin
                result.count = 2'd1;
                result.cp[0] = CP_REPLACEMENT;
            end
        end else if (in_byte == '0) begin
            // Truncated sequence: replace the lead, then rescan the held bytes.
            result.cp[0] = CP_REPLACEMENT;
            case (held_cnt_reg)
                2'd1: begin
                    result.count = 2'd2;
                    result.cp[1] = is_ascii(c0) ? from_ascii(c0) : CP_REPLACEMENT;
                end
                2'd2: begin
                    if (is_lead2(c0)) begin
                        result.count = 2'd2;
                        result.cp[1] = join2(c0, c1);
                    end else begin
                        result.count = 2'd3;
                        result.cp[1] = is_ascii(c0) ? from_ascii(c0) : CP_REPLACEMENT;
                        result.cp[2] = is_ascii(c1) ? from_ascii(c1) : CP_REPLACEMENT;
                    end
                end
                default: begin
                    result.count = 2'd1;
                end
            endcase
            lead_next     = '0;
            needed_next   = 2'd0;
            held_cnt_next = 2'd0;
        end else if (({1'b0, held_cnt_reg} + 3'd1) >= {1'b0, needed_reg}) begin
            result.count = 2'd1;
            case (needed_reg)
                2'd1:    result.cp[0] = join2(lead_reg, in_byte);
                2'd2:    result.cp[0] = join3(lead_reg, c0, in_byte);
                default: result.cp[0] = join4(lead_reg, c0, c1, in_byte);
            endcase
            lead_next     = '0;
            needed_next   = 2'd0;
            held_cnt_next = 2'd0;
        end else begin
            held_wr       = 1'b1;
            held_cnt_next = held_cnt_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lead_reg     <= '0;
            needed_reg   <= 2'd0;
            held_cnt_reg <= 2'd0;
        end else if (in_accept) begin
            lead_reg     <= lead_next;
            needed_reg   <= needed_next;
            held_cnt_reg <= held_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && held_wr) begin
            held_reg[held_cnt_reg[0]] <= in_byte;
        end
    end

endmodule

### design/utf8ld_result_queue.sv
// Result queue for the lenient UTF-8 decoder: takes a burst of up to three
// code points in one cycle and hands them out one beat at a time.
// Depends on utf8ld_pkg.
module utf8ld_result_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  utf8ld_pkg::step_result_t      burst,
    output logic                          room,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [utf8ld_pkg::CpW-1:0]    out_code_point,
    output logic                          out_last
);
    import utf8ld_pkg::*;

    localparam int IdxW = $clog2(QueueDepth);
    localparam int CntW = $clog2(QueueDepth + 1);

    logic [CpW-1:0]  cp_mem   [QueueDepth];
    logic            last_mem [QueueDepth];
    logic [IdxW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg, count_next;
    logic            pop;
    logic [CntW-1:0] push_n;

    assign out_valid      = (count_reg != '0);
    assign out_code_point = cp_mem[rd_ptr_reg];
    assign out_last       = last_mem[rd_ptr_reg];
    assign pop            = out_valid && out_ready;
    assign push_n         = push ? CntW'(burst.count) : '0;
    // Enough free slots for a full burst, decided from registers alone.
    assign room           = (count_reg <= CntW'(QueueDepth - MaxResults));
    assign count_next     = count_reg + push_n - CntW'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + IdxW'(push_n);
            rd_ptr_reg <= rd_ptr_reg + IdxW'(pop);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < MaxResults; k++) begin
            if (push && (CountW'(k) < burst.count)) begin
                cp_mem[wr_ptr_reg + IdxW'(k)]   <= burst.cp[k];
                last_mem[wr_ptr_reg + IdxW'(k)] <= (CountW'(k) == burst.count - 2'd1);
            end
        end
    end

endmodule

### design/utf8_lenient_decoder_core.sv
// Lenient UTF-8 decoder, top level: byte decoder feeding a small result queue.
// Depends on utf8ld_pkg, utf8ld_decode and utf8ld_result_queue.
//
// Usage:
//   The s_ channel carries one string byte per beat; a zero byte ends the
//   string. The m_ channel carries one decoded code point per beat, with
//   m_last_of_run high on the final result caused by an input byte.
//   ASCII bytes and the last byte of a 2, 3 or 4 byte sequence each give one
//   result; bad lead bytes give U+FFFD. A terminator inside an open sequence
//   gives U+FFFD followed by a rescan of any held bytes: one to three results.
//   An empty queue presents a result on m_ the cycle after its byte is taken.
//   Throughput: one byte per cycle while each byte gives at most one result
//   and m_ready stays high. A byte that gives two or three results holds
//   s_ready low while the four-entry result queue drains. When the receiver
//   stalls, results wait in the queue; s_ready drops once more than one
//   result is waiting, so no result is lost.
//   Reset (aresetn, synchronous, active low) closes any open sequence and
//   empties the queue; s_ready is high in the first cycle after reset.
module utf8_lenient_decoder_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [utf8ld_pkg::ByteW-1:0]  s_text_byte,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [utf8ld_pkg::CpW-1:0]    m_code_point,
    output logic                          m_last_of_run
);
    import utf8ld_pkg::*;

    logic         accept;
    step_result_t burst;

    assign accept = s_valid && s_ready;

    utf8ld_decode u_decode (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_byte   (s_text_byte),
        .in_accept (accept),
        .result    (burst)
    );

    utf8ld_result_queue u_queue (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .push           (accept),
        .burst          (burst),
        .room           (s_ready),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_code_point (m_code_point),
        .out_last       (m_last_of_run)
    );

endmodule

### design/utf8ld_checker.sv
// Port-level checks for the lenient UTF-8 decoder, bound to the top level.
// Depends on utf8ld_pkg and utf8_lenient_decoder_core.
module utf8ld_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_ready,
    input  logic                          m_valid,
    input  logic                          m_ready,
    input  logic [utf8ld_pkg::CpW-1:0]    m_code_point,
    input  logic                          m_last_of_run
);
    import utf8ld_pkg::*;

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_code_point) && $stable(m_last_of_run))
        else $error("result beat changed while stalled");

    // Reset empties the result queue.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A result that is not the last of its run always has a successor queued.
    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |=> m_valid)
        else $error("run ended without a last beat");

    // Input is only held off while results are waiting.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no pending results");

    // Early results of a run come from the rescan: replacement or ASCII only.
    a_early_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_last_of_run |-> m_code_point == CP_REPLACEMENT || m_code_point < 21'd128)
        else $error("unexpected code point before last of run");

endmodule

bind utf8_lenient_decoder_core utf8ld_checker u_utf8ld_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_code_point  (m_code_point),
    .m_last_of_run (m_last_of_run)
);
